// ===== design/b58e_pkg.sv =====
// Shared types, constants and helpers for the base58 byte-string encoder.
package b58e_pkg;

    localparam int MAX_BYTES_DEF  = 32;
    localparam int MAX_DIGITS_DEF = 44;
    localparam int OUT_CAP        = 44;

    localparam int DIGIT_W = 6;
    localparam int CARRY_W = 8;
    localparam int DIV_W   = DIGIT_W + CARRY_W;
    localparam int PROD_W  = 29;
    localparam int DIV_SHIFT = 20;

    localparam logic [14:0]        RECIP_58  = 15'd18079;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd57;
    localparam logic [6:0]         CHAR_ONE  = 7'd49;

    localparam logic [58*8-1:0] B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_text;
        logic       overflowed;
    } t_out_beat;

    typedef struct packed {
        logic take;        // input beat accepted
        logic walk;        // process one stored digit
        logic grow;        // append one carry digit
        logic emit_setup;  // latch character count
        logic emit_read;   // fetch the next digit
        logic emit_load;   // load one character into the output register
        logic clear;       // string done, return to reset values
    } t_dp_cmd;

    typedef struct packed {
        logic room;
        logic walk_done;
        logic carry_zero;
        logic remain_zero;
        logic last_char;
        logic out_free;
    } t_dp_stat;

    // Digit to ASCII; first alphabet character sits in the top byte.
    function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dc;
        logic [DIGIT_W-1:0] rev;
        dc  = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        rev = DIGIT_MAX - dc;
        return B58_ALPHABET[{rev, 3'b000} +: 7];
    endfunction

endpackage

// ===== design/base58_byte_string_encoder.sv =====
// Top level of the base58 (Bitcoin alphabet) byte-string encoder.
//
// Bytes of a string arrive one per input beat; final_byte marks the last one.
// Each byte multiplies the stored base-58 number by 256 and adds the byte:
// a single divide-by-58 unit walks the digit store one digit per cycle, then
// appends the leftover carry as new digits (at most two). Leading zero
// bytes are counted separately and come out as '1' characters. After the
// final byte the block emits the encoding as output beats, each character
// taking one memory read, then one output register load once the sink is
// free: the '1' run first, then the digits from most to least significant,
// end_of_text on the last one. The output is cut at 44 characters. overflowed
// is set on every character of a string in which a byte past MAX_BYTES was
// dropped, a carry found the digit store full, or the output was cut. A
// dropped final byte still starts the emission. After the last character is
// loaded into the output register, the state clears and the next string may
// start while that character still waits for the sink. No input beat is
// taken while a byte or an emission is in progress.
module base58_byte_string_encoder import b58e_pkg::*; #(
    parameter int MAX_BYTES  = MAX_BYTES_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Phase sequencing
    b58e_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_final_byte (i_in.final_byte),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat)
    );

    // Digit store, arithmetic and output register
    b58e_dp #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_data_byte (i_in.data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== design/b58e_ctrl.sv =====
// Sequencer for the base58 encoder: absorb, grow and emit phases.
module b58e_ctrl import b58e_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_final_byte,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_GROW   = 3'd2;
    localparam logic [2:0] S_ESETUP = 3'd3;
    localparam logic [2:0] S_EADDR  = 3'd4;
    localparam logic [2:0] S_ELOAD  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_final, n_final;

    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_final    = i_final_byte;
                    if (i_stat.room) begin
                        n_state = S_WALK;
                    end else if (i_final_byte) begin
                        n_state = S_ESETUP;
                    end
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_GROW;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_GROW: begin
                if (i_stat.carry_zero) begin
                    n_state = r_final ? S_ESETUP : S_IDLE;
                end else begin
                    o_cmd.grow = 1'b1;
                end
            end
            S_ESETUP: begin
                o_cmd.emit_setup = 1'b1;
                n_state          = S_EADDR;
            end
            S_EADDR: begin
                if (i_stat.remain_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.emit_read = 1'b1;
                    n_state         = S_ELOAD;
                end
            end
            S_ELOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_stat.last_char) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_EADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

endmodule

// ===== design/b58e_dp.sv =====
// Datapath: digit store, divide-by-58 step, counters and output register.
module b58e_dp import b58e_pkg::*; #(
    parameter int MAX_BYTES  = MAX_BYTES_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out
);

    localparam int ZW  = $clog2(MAX_BYTES + 1);
    localparam int DW  = $clog2(MAX_DIGITS + 1);
    localparam int AW  = $clog2(MAX_DIGITS);
    localparam int RW  = $clog2(OUT_CAP + 1);
    localparam int TW0 = (ZW > DW) ? ZW : DW;
    localparam int TW  = ((TW0 > RW) ? TW0 : RW) + 1;

    logic [DIGIT_W-1:0] r_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rdata;

    logic [CARRY_W-1:0] r_carry,     n_carry;
    logic [DW-1:0]      r_idx,       n_idx;
    logic [DW-1:0]      r_used,      n_used;
    logic [ZW-1:0]      r_zero_run,  n_zero_run;
    logic               r_leading,   n_leading;
    logic [ZW-1:0]      r_bytes,     n_bytes;
    logic               r_ovf,       n_ovf;
    logic [ZW-1:0]      r_zleft,     n_zleft;
    logic [AW-1:0]      r_pos,       n_pos;
    logic [RW-1:0]      r_remain,    n_remain;
    t_out_beat          r_out,       n_out;
    logic               r_out_valid, n_out_valid;

    logic [DIV_W-1:0]   div_in;
    logic [PROD_W-1:0]  prod;
    logic [CARRY_W-1:0] quo;
    logic [DIV_W-1:0]   quo_x58;
    logic [DIGIT_W-1:0] rem;
    logic [DW-1:0]      idx_inc;
    logic [TW-1:0]      total;
    logic               full;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic               out_free;

    // value = carry + 256 * digit during the walk, carry alone while growing
    assign div_in  = i_cmd.walk ? ({r_rdata, {CARRY_W{1'b0}}} + DIV_W'(r_carry))
                                : DIV_W'(r_carry);
    // floor(v / 58) by reciprocal; exact for all values up to 14847 (57 * 256 + 255), the largest the walk forms
    assign prod    = PROD_W'(div_in) * PROD_W'(RECIP_58);
    assign quo     = prod[DIV_SHIFT +: CARRY_W];
    assign quo_x58 = DIV_W'({quo, 6'b0}) - DIV_W'({quo, 2'b0}) - DIV_W'({quo, 1'b0});
    assign rem     = DIGIT_W'(div_in - quo_x58);

    assign idx_inc  = r_idx + DW'(1);
    assign total    = TW'(r_zero_run) + TW'(r_used);
    assign full     = (r_used == DW'(MAX_DIGITS));
    assign out_free = !r_out_valid || i_out_ready;

    assign mem_we = i_cmd.walk || (i_cmd.grow && !full);
    // read data holds while a character waits for the output register
    assign mem_re = i_cmd.take || i_cmd.walk || i_cmd.emit_read;
    assign mem_wa = i_cmd.walk ? r_idx[AW-1:0] : r_used[AW-1:0];
    assign mem_ra = i_cmd.walk      ? idx_inc[AW-1:0] :
                    i_cmd.emit_read ? r_pos : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= rem;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_comb begin
        n_carry     = r_carry;
        n_idx       = r_idx;
        n_used      = r_used;
        n_zero_run  = r_zero_run;
        n_leading   = r_leading;
        n_bytes     = r_bytes;
        n_ovf       = r_ovf;
        n_zleft     = r_zleft;
        n_pos       = r_pos;
        n_remain    = r_remain;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.take) begin
            if (r_bytes < ZW'(MAX_BYTES)) begin
                n_carry = i_data_byte;
                n_idx   = '0;
                n_bytes = r_bytes + ZW'(1);
                if (r_leading) begin
                    if (i_data_byte == 8'd0) begin
                        n_zero_run = r_zero_run + ZW'(1);
                    end else begin
                        n_leading = 1'b0;
                    end
                end
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_cmd.walk) begin
            n_carry = quo;
            n_idx   = idx_inc;
        end

        if (i_cmd.grow) begin
            if (full) begin
                n_ovf   = 1'b1;
                n_carry = '0;
            end else begin
                n_carry = quo;
                n_used  = r_used + DW'(1);
            end
        end

        if (i_cmd.emit_setup) begin
            n_zleft = r_zero_run;
            n_pos   = AW'(r_used - DW'(1));
            if (total > TW'(OUT_CAP)) begin
                n_remain = RW'(OUT_CAP);
                n_ovf    = 1'b1;
            end else begin
                n_remain = RW'(total);
            end
        end

        if (i_cmd.emit_load) begin
            n_out_valid       = 1'b1;
            n_out.end_of_text = (r_remain == RW'(1));
            n_out.overflowed  = r_ovf;
            n_remain          = r_remain - RW'(1);
            if (r_zleft != '0) begin
                n_out.out_char = CHAR_ONE;
                n_zleft        = r_zleft - ZW'(1);
            end else begin
                n_out.out_char = b58_char(r_rdata);
                n_pos          = r_pos - AW'(1);
            end
        end

        if (i_cmd.clear) begin
            n_used     = '0;
            n_zero_run = '0;
            n_leading  = 1'b1;
            n_bytes    = '0;
            n_ovf      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_zero_run  <= '0;
            r_leading   <= 1'b1;
            r_bytes     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_remain    <= '0;
        end else begin
            r_used      <= n_used;
            r_zero_run  <= n_zero_run;
            r_leading   <= n_leading;
            r_bytes     <= n_bytes;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_remain    <= n_remain;
        end
        r_carry <= n_carry;
        r_idx   <= n_idx;
        r_zleft <= n_zleft;
        r_pos   <= n_pos;
        r_out   <= n_out;
    end

    assign o_stat.room        = (r_bytes < ZW'(MAX_BYTES));
    assign o_stat.walk_done   = (r_idx == r_used);
    assign o_stat.carry_zero  = (r_carry == '0);
    assign o_stat.remain_zero = (r_remain == '0);
    assign o_stat.last_char   = (r_remain == RW'(1));
    assign o_stat.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== dv/base58_byte_string_encoder_test.sv =====
// Testbench for the base58 byte-string encoder: directed and random strings, scoreboard check.
`timescale 1ns / 100ps

module base58_byte_string_encoder_test;
    import b58e_pkg::*;

    localparam int MAX_BYTES      = MAX_BYTES_DEF;
    localparam int MAX_DIGITS     = MAX_DIGITS_DEF;
    localparam int RESET_CYCLES   = 6;
    // Receiver hold-off long enough for the block to finish a string and back up.
    localparam int HOLD_CYCLES    = 400;
    // Longest correct stretch without a beat: hold-off plus one byte walk plus
    // sender gaps; taken several times over.
    localparam int WATCHDOG_LIMIT = 3000;
    // Drain time after the scoreboard empties.
    localparam int DRAIN_CYCLES   = 120;
    localparam logic [7:0] LEAD_ZERO_GLYPH = "1";

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out;

    base58_byte_string_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Encoder predictor: base-58 digit array, least significant first.
    // ------------------------------------------------------------------
    string       glyphs = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    logic [5:0]  enc_digits [MAX_DIGITS];
    int unsigned enc_used;
    int unsigned enc_zero_run;
    bit          enc_leading;
    int unsigned enc_taken;
    bit          enc_dropped;

    // Characters the block still owes, oldest first.
    t_out_beat   expected_chars [$];

    // Stimulus control.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent    = 0;
    int          hold_requests = 0;
    logic [7:0]  string_bytes [$];

    // Checker and watchdog state.
    int          errors      = 0;
    int          idle_cycles = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    t_out_beat   head_char;

    function void encoder_clear();
        for (int i = 0; i < MAX_DIGITS; i++)
            enc_digits[i] = '0;
        enc_used     = 0;
        enc_zero_run = 0;
        enc_leading  = 1'b1;
        enc_taken    = 0;
        enc_dropped  = 1'b0;
    endfunction

    // Number * 256 + b, one digit at a time, then grow with the leftover carry.
    function void absorb_into_digits(input logic [7:0] b);
        int unsigned carry;
        carry = b;
        if (enc_leading) begin
            if (b == 8'd0)
                enc_zero_run++;
            else
                enc_leading = 1'b0;
        end
        for (int i = 0; i < enc_used; i++) begin
            carry += 256 * 32'(enc_digits[i]);
            enc_digits[i] = 6'(carry % 58);
            carry /= 58;
        end
        while (carry > 0) begin
            if (enc_used >= MAX_DIGITS) begin
                // digit store full: carry lost
                enc_dropped = 1'b1;
                break;
            end
            enc_digits[enc_used] = 6'(carry % 58);
            enc_used++;
            carry /= 58;
        end
    endfunction

    // Called once per accepted input beat; queues the string's characters
    // when the final byte arrives.
    function void take_byte(input t_in_beat beat);
        int unsigned n;
        int unsigned pos;
        logic [7:0]  ch;
        t_out_beat   c;
        if (enc_taken < MAX_BYTES) begin
            absorb_into_digits(beat.data_byte);
            enc_taken++;
        end else begin
            // past capacity: dropped, but a final flag still counts
            enc_dropped = 1'b1;
        end
        if (!beat.final_byte)
            return;
        n = enc_zero_run + enc_used;
        if (n > OUT_CAP) begin
            n = OUT_CAP;
            enc_dropped = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            if (k < enc_zero_run) begin
                ch = LEAD_ZERO_GLYPH;
            end else begin
                pos = enc_used - 1 - (k - enc_zero_run);
                ch  = glyphs[enc_digits[pos]];
            end
            c.out_char    = ch[6:0];
            c.end_of_text = (k + 1 == n);
            c.overflowed  = enc_dropped;
            expected_chars.push_back(c);
        end
        encoder_clear();
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat, with a random gap before it.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_in_beat beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        take_byte(beat);
        items_sent++;
    endtask

    // Sends string_bytes as one string, final flag on the last byte.
    task automatic send_string();
        t_in_beat beat;
        for (int i = 0; i < string_bytes.size(); i++) begin
            beat.data_byte  = string_bytes[i];
            beat.final_byte = (i == string_bytes.size() - 1);
            send_beat(beat);
        end
        string_bytes.delete();
    endtask

    // Biased random byte: plenty of 0x00 and 0xFF.
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_single_bytes();
        // smallest and largest byte, one- and two-digit boundaries
        string_bytes = '{8'h00};
        send_string();
        string_bytes = '{8'hFF};
        send_string();
        string_bytes = '{8'h01};
        send_string();
        string_bytes = '{8'd57};
        send_string();
        string_bytes = '{8'd58};
        send_string();
    endtask

    task automatic test_leading_zeros();
        // zero run then a value; a zero after a nonzero byte is a digit
        string_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_string();
        string_bytes = '{8'h00, 8'h00};
        send_string();
        string_bytes = '{8'h00, 8'h7F, 8'h00, 8'h80};
        send_string();
    endtask

    task automatic test_max_value();
        // 2^256 - 1: fills every digit
        for (int i = 0; i < MAX_BYTES; i++)
            string_bytes.push_back(8'hFF);
        send_string();
    endtask

    task automatic test_capacity();
        // bytes past capacity are dropped and flagged
        for (int i = 0; i < MAX_BYTES + 3; i++)
            string_bytes.push_back(pick_byte());
        send_string();
        // only the final byte lands past capacity; it still starts the output
        for (int i = 0; i < MAX_BYTES + 1; i++)
            string_bytes.push_back(8'($urandom_range(1, 255)));
        send_string();
    endtask

    task automatic test_output_backpressure();
        // receiver stops for a long stretch while strings keep coming
        hold_requests <= hold_requests + 1;
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 6; i++)
                string_bytes.push_back(pick_byte());
            send_string();
        end
    endtask

    task automatic test_random_strings(input int item_goal);
        int goal;
        int len;
        int zeros;
        int r;
        goal = items_sent + item_goal;
        while (items_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 90)
                len = $urandom_range(9, MAX_BYTES);
            else
                len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
            zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            for (int i = 0; i < len; i++)
                string_bytes.push_back((i < zeros) ? 8'h00 : pick_byte());
            send_string();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, or a counted hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Scoreboard: every output beat against the oldest expected character.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected output beat: out_char %0d end_of_text %0d overflowed %0d",
                       o_out.out_char, o_out.end_of_text, o_out.overflowed);
                errors++;
            end else begin
                head_char = expected_chars.pop_front();
                if (o_out.out_char !== head_char.out_char) begin
                    $error("out_char: expected %0d, got %0d",
                           head_char.out_char, o_out.out_char);
                    errors++;
                end
                if (o_out.end_of_text !== head_char.end_of_text) begin
                    $error("end_of_text: expected %0d, got %0d",
                           head_char.end_of_text, o_out.end_of_text);
                    errors++;
                end
                if (o_out.overflowed !== head_char.overflowed) begin
                    $error("overflowed: expected %0d, got %0d",
                           head_char.overflowed, o_out.overflowed);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("base58_byte_string_encoder_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        encoder_clear();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender sparse-ish, receiver busy
        send_idle_pct = 25;
        recv_idle_pct <= 55;
        test_single_bytes();
        test_leading_zeros();
        test_max_value();
        test_capacity();
        test_output_backpressure();
        test_random_strings(110);

        // sender slow, receiver mostly ready
        send_idle_pct = 55;
        recv_idle_pct <= 25;
        test_random_strings(110);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_random_strings(110);

        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_chars.size() == 0) begin
            $display("base58_byte_string_encoder_test: PASS");
        end else begin
            $display("base58_byte_string_encoder_test: FAIL");
        end
        $finish;
    end

endmodule
